// ===== src/cal_pkg.sv =====
package cal_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned PORT_CH_W        = 8;
  localparam int unsigned MASK_W           = 8;
  localparam int unsigned SHORT_W          = 7;
  localparam int unsigned LIMIT_W          = 12;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 12;
  localparam int unsigned COUNT_W          = 8;
  localparam int unsigned DIST_W           = COUNT_W + 1;
  localparam int unsigned LEN_W            = 9;
  localparam int unsigned IN_DATA_W        = 32;
  localparam int unsigned OUT_DATA_W       = 16;

  // 0.3 * sqrt(s) < L / 16  <=>  2304 * s < 100 * L^2
  localparam int unsigned DIST_SCALE       = 2304;
  localparam int unsigned DIST_SCALE_W     = 12;
  localparam int unsigned LIMIT_SCALE      = 100;
  localparam int unsigned LIMIT_SQ_W       = 31;

  localparam logic [SHORT_W-1:0] ARM_SHORT_RST  = SHORT_W'(10);
  localparam logic [LIMIT_W-1:0] LIMIT_NEAR_RST = LIMIT_W'(320);
  localparam logic [LIMIT_W-1:0] LIMIT_FAR_RST  = LIMIT_W'(96);

  localparam logic [MASK_W-1:0] MASK_FULL = '1;
  localparam logic [MASK_W-1:0] MASK_NONE = '0;
  localparam logic [LEN_W-1:0]  LEN_MASKED_OUT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_SHORT  = 2'd0,
    REG_LIMIT_NEAR = 2'd1,
    REG_LIMIT_FAR  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_CENTER = 1'b0,
    KIND_ARM    = 1'b1
  } pixel_kind_e;

  function automatic logic [LIMIT_SQ_W-1:0] limit_sq(input logic [LIMIT_W-1:0] lim);
    logic [2*LIMIT_W-1:0] sq;
    sq = lim * lim;
    return LIMIT_SQ_W'(sq) * LIMIT_SQ_W'(LIMIT_SCALE);
  endfunction

endpackage

// ===== src/cal_sq_dist.sv =====
module cal_sq_dist #(
  parameter int unsigned CHANNEL_BITS = cal_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned OUT_W        = 2 * CHANNEL_BITS + 2 + cal_pkg::DIST_SCALE_W
) (
  input  logic [2:0][CHANNEL_BITS-1:0] a_i,
  input  logic [2:0][CHANNEL_BITS-1:0] b_i,
  output logic [OUT_W-1:0]             scaled_o
);

  localparam int unsigned SQ_W  = 2 * CHANNEL_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;

  logic [2:0][CHANNEL_BITS-1:0] diff;
  logic [2:0][SQ_W-1:0]         sq;
  logic [SUM_W-1:0]             sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (a_i[i] > b_i[i]) ? (a_i[i] - b_i[i]) : (b_i[i] - a_i[i]);
      sq[i]   = diff[i] * diff[i];
    end
    sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  // 2304 = 2048 + 256
  assign scaled_o = (OUT_W'(sum) << 11) + (OUT_W'(sum) << 8);

endmodule

// ===== src/cross_arm_length.sv =====
// cross_arm_length: one arm of a cross-shaped support region.
// input stream: tuser = kind (0 center, 1 arm pixel), tlast = last pixel of
//   the line in this direction, tdata = red, green, blue, mask byte.
// output stream: tdata[8:0] = signed arm length, -1 for a masked-out center.
// a center opens an arm (or answers -1, or 0 when it is also last); arm
//   pixels follow outward and the length comes out at the first rejected
//   pixel or at the last one. arm pixels with no open arm give no item.
// config: write enable, register index and data; 0 arm_short,
//   1 color_limit_near, 2 color_limit_far. write only while idle.
// timing: one item per cycle while the receiver takes results. an accepted
//   input passes the input register, then the distance squares and the limit
//   compares feeding the result register. arm state updates on the edge that
//   loads the result register so the next pixel sees it with no bubble.
// reset clears config to defaults and closes any arm; no clearing pass.
// a stalled receiver holds the result register; one more item is still
//   taken into the input register, then tready drops until m_axis_tready
//   returns.
module cross_arm_length #(
  parameter int unsigned CHANNEL_BITS = cal_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cal_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cal_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], mask_value [31:24]
  input  logic [cal_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // kind
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // arm_length [8:0], zeros [15:9]
  output logic [cal_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned EXT_W  = (CB > cal_pkg::PORT_CH_W) ? CB : cal_pkg::PORT_CH_W;
  localparam int unsigned SC_W   = 2 * CB + 2 + cal_pkg::DIST_SCALE_W;
  localparam int unsigned CMP_W  = (SC_W > cal_pkg::LIMIT_SQ_W) ? SC_W : cal_pkg::LIMIT_SQ_W;
  localparam int unsigned PCW    = cal_pkg::PORT_CH_W;
  localparam int unsigned DW     = cal_pkg::DIST_W;
  localparam int unsigned SW     = cal_pkg::SHORT_W;

  // config
  logic [SW-1:0]                      arm_short_q;
  logic [cal_pkg::LIMIT_W-1:0]        lim_near_q, lim_far_q;
  logic [cal_pkg::LIMIT_SQ_W-1:0]     near_sq_q, far_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_short_q <= cal_pkg::ARM_SHORT_RST;
      lim_near_q  <= cal_pkg::LIMIT_NEAR_RST;
      lim_far_q   <= cal_pkg::LIMIT_FAR_RST;
      near_sq_q   <= cal_pkg::limit_sq(cal_pkg::LIMIT_NEAR_RST);
      far_sq_q    <= cal_pkg::limit_sq(cal_pkg::LIMIT_FAR_RST);
    end else begin
      near_sq_q <= cal_pkg::limit_sq(lim_near_q);
      far_sq_q  <= cal_pkg::limit_sq(lim_far_q);
      if (cfg_we_i) begin
        case (cal_pkg::cfg_reg_e'(cfg_index_i))
          cal_pkg::REG_ARM_SHORT:  arm_short_q <= cfg_data_i[SW-1:0];
          cal_pkg::REG_LIMIT_NEAR: lim_near_q  <= cfg_data_i[cal_pkg::LIMIT_W-1:0];
          cal_pkg::REG_LIMIT_FAR:  lim_far_q   <= cfg_data_i[cal_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input register
  logic                            advance, s_accept, process;
  logic                            in_valid_q;
  logic                            in_kind_q, in_last_q;
  logic [2:0][CB-1:0]              in_col_q;
  logic [cal_pkg::MASK_W-1:0]      in_mask_q;
  logic [2:0][CB-1:0]              col_d;
  logic [2:0][EXT_W-1:0]           col_ext;

  logic                            out_valid_q;
  logic [cal_pkg::LEN_W-1:0]       out_len_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && advance;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_ext[i] = EXT_W'(s_axis_tdata[i*PCW +: PCW]);
      col_d[i]   = col_ext[i][CB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
      in_col_q  <= col_d;
      in_mask_q <= s_axis_tdata[3*PCW +: cal_pkg::MASK_W];
    end
  end

  // arm state and tests
  logic [2:0][CB-1:0]              center_q, prev_q;
  logic [cal_pkg::COUNT_W-1:0]     count_q;
  logic                            active_q;
  logic [SC_W-1:0]                 sc_cen, sc_pre;
  logic [DW-1:0]                   arm_dist;
  logic                            near_ok, far_ok, ok;

  cal_sq_dist #(.CHANNEL_BITS(CB), .OUT_W(SC_W)) u_sq_cen (
    .a_i      (in_col_q),
    .b_i      (center_q),
    .scaled_o (sc_cen)
  );

  cal_sq_dist #(.CHANNEL_BITS(CB), .OUT_W(SC_W)) u_sq_pre (
    .a_i      (in_col_q),
    .b_i      (prev_q),
    .scaled_o (sc_pre)
  );

  always_comb begin
    arm_dist = DW'(count_q) + DW'(1);
    near_ok  = (CMP_W'(sc_cen) < CMP_W'(near_sq_q)) && (CMP_W'(sc_pre) < CMP_W'(near_sq_q));
    far_ok   = (arm_dist < DW'(arm_short_q)) || (CMP_W'(sc_cen) < CMP_W'(far_sq_q));
    ok       = (in_mask_q != cal_pkg::MASK_NONE) && (arm_dist < (DW'(arm_short_q) << 1))
               && near_ok && far_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= '0;
      prev_q      <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b0;
      if (process) begin
        if (in_kind_q == cal_pkg::KIND_CENTER) begin
          count_q  <= '0;
          active_q <= 1'b0;
          if (in_mask_q != cal_pkg::MASK_FULL) begin
            out_valid_q <= 1'b1;
            out_len_q   <= cal_pkg::LEN_MASKED_OUT;
          end else begin
            center_q <= in_col_q;
            prev_q   <= in_col_q;
            if (in_last_q) begin
              out_valid_q <= 1'b1;
              out_len_q   <= '0;
            end else begin
              active_q <= 1'b1;
            end
          end
        end else if (active_q) begin
          if (ok) begin
            count_q <= arm_dist[cal_pkg::COUNT_W-1:0];
            prev_q  <= in_col_q;
          end
          if (!ok || in_last_q) begin
            active_q    <= 1'b0;
            out_valid_q <= 1'b1;
            out_len_q   <= ok ? cal_pkg::LEN_W'(arm_dist[cal_pkg::COUNT_W-1:0])
                              : cal_pkg::LEN_W'(count_q);
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cal_pkg::OUT_DATA_W'(out_len_q);

endmodule
